/* hdl/dtbs_pkg.sv */
// Shared types, constants and band lookup for the DDS tuning word and band selector.
`timescale 1ns / 1ps

package dtbs_pkg;

    // Field widths.
    localparam int HZ_W       = 36;
    localparam int WORD_W     = 32;
    localparam int PATH_W     = 3;
    localparam int PATH_COUNT = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // Fixed band limits in Hz.
    localparam logic [HZ_W-1:0] LOW_BAND_MIN_HZ  = 36'd20000000;
    localparam logic [HZ_W-1:0] LOW_BAND_MAX_HZ  = 36'd1000000000;
    localparam logic [HZ_W-1:0] MID_BAND_MIN_HZ  = 36'd1000000000;
    localparam logic [HZ_W-1:0] MID_BAND_MAX_HZ  = 36'd6000000000;
    localparam logic [HZ_W-1:0] HIGH_BAND_MIN_HZ = 36'd6000000000;
    localparam logic [HZ_W-1:0] HIGH_BAND_MAX_HZ = 36'd18000000000;

    // Register reset values.
    localparam logic [HZ_W-1:0] RST_SYNTH_CLOCK_HZ = 36'd3000000000;
    localparam logic [HZ_W-1:0] RST_PATH1_MIN_HZ   = 36'd1000000000;
    localparam logic [HZ_W-1:0] RST_PATH1_MAX_HZ   = 36'd1400000000;
    localparam logic [HZ_W-1:0] RST_PATH2_MAX_HZ   = 36'd2000000000;
    localparam logic [HZ_W-1:0] RST_PATH3_MAX_HZ   = 36'd2800000000;
    localparam logic [HZ_W-1:0] RST_PATH4_MAX_HZ   = 36'd4000000000;
    localparam logic [HZ_W-1:0] RST_PATH5_MAX_HZ   = 36'd6000000000;

    // Band selector codes.
    typedef enum logic [1:0] {
        BAND_LOW     = 2'd0,
        BAND_MID     = 2'd1,
        BAND_HIGH    = 2'd2,
        BAND_INVALID = 2'd3
    } t_band;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SYNTH_CLOCK = 3'd0,
        CFG_BAND_SELECT = 3'd1,
        CFG_PATH1_MIN   = 3'd2,
        CFG_PATH1_MAX   = 3'd3,
        CFG_PATH2_MAX   = 3'd4,
        CFG_PATH3_MAX   = 3'd5,
        CFG_PATH4_MAX   = 3'd6,
        CFG_PATH5_MAX   = 3'd7
    } t_cfg_index;

    // Doubler path edges handed to the path selector.
    typedef struct packed {
        logic [HZ_W-1:0]                 min_hz;
        logic [PATH_COUNT-1:0][HZ_W-1:0] max_hz;
    } t_path_bounds;

    // Divider result handed back to the top level.
    typedef struct packed {
        logic              ovf;
        logic [WORD_W-1:0] word;
    } t_div_result;

    // True when the frequency lies inside the selected band.
    function automatic logic band_fits(input logic [HZ_W-1:0] f, input t_band b);
        logic fits;
        case (b)
            BAND_LOW:     fits = (f >= LOW_BAND_MIN_HZ) && (f <= LOW_BAND_MAX_HZ);
            BAND_MID:     fits = (f >= MID_BAND_MIN_HZ) && (f <= MID_BAND_MAX_HZ);
            BAND_HIGH:    fits = (f >= HIGH_BAND_MIN_HZ) && (f <= HIGH_BAND_MAX_HZ);
            BAND_INVALID: fits = 1'b0;
            default:      fits = 1'b0;
        endcase
        return fits;
    endfunction

endpackage

/* hdl/dds_tuning_word_band_select_top.sv */
// Top level of the DDS tuning word and band selector: registers, sequencer and output stage.
`timescale 1ns / 1ps

// Each request on the input stream carries a frequency in Hz; it is stored when it lies
// between 20 MHz and 18 GHz, else the last stored frequency (zero after reset) is reused.
// One result is returned per request: the accept flag, the band check against the
// band_select register, the doubler path code, and floor(f * 2^32 / synth_clock_hz) with
// an overflow flag, where f is halved in the mid band when the path code is not zero. The
// path search tests one edge per cycle and the tuning word comes from a bit-serial divider
// that makes one quotient bit per cycle and skips the iterations when the word overflows.
// One request is processed at a time; the next one is taken as soon as the previous
// result is in the output register. Configuration registers must be written by the user
// only while no request is in progress; the block itself does not enforce this.

module dds_tuning_word_band_select_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [dtbs_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [dtbs_pkg::HZ_W-1:0]             i_cfg_data,
    // Request stream.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: request_freq_hz [35:0], zero fill [39:36].
    input  logic [dtbs_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // Result stream.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: accepted [0], band_ok [1], doubler_path [4:2], tuning_word [36:5],
    // tuning_overflow [37], zero fill [39:38].
    output logic [dtbs_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
    import dtbs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PATH = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [HZ_W-1:0]     r_synth_clock;
    t_band               r_band;
    t_path_bounds        r_bounds;
    logic [HZ_W-1:0]     r_kept;
    logic                r_acc;
    logic [PATH_W-1:0]   r_path;
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                w_in_accept;
    logic                w_req_ok;
    logic [HZ_W-1:0]     w_req;
    logic                w_out_free;
    logic                w_path_done;
    logic [PATH_W-1:0]   w_path;
    logic                w_div_start;
    logic [HZ_W-1:0]     w_dds;
    logic                w_div_done;
    t_div_result         w_div_result;

    assign w_req       = s_axis_tdata[HZ_W-1:0];
    assign w_req_ok    = (w_req >= LOW_BAND_MIN_HZ) && (w_req <= HIGH_BAND_MAX_HZ);
    assign w_in_accept = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synth_clock      <= RST_SYNTH_CLOCK_HZ;
            r_band             <= BAND_LOW;
            r_bounds.min_hz    <= RST_PATH1_MIN_HZ;
            r_bounds.max_hz[0] <= RST_PATH1_MAX_HZ;
            r_bounds.max_hz[1] <= RST_PATH2_MAX_HZ;
            r_bounds.max_hz[2] <= RST_PATH3_MAX_HZ;
            r_bounds.max_hz[3] <= RST_PATH4_MAX_HZ;
            r_bounds.max_hz[4] <= RST_PATH5_MAX_HZ;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_addr))
                CFG_SYNTH_CLOCK: r_synth_clock      <= i_cfg_data;
                CFG_BAND_SELECT: r_band             <= t_band'(i_cfg_data[1:0]);
                CFG_PATH1_MIN:   r_bounds.min_hz    <= i_cfg_data;
                CFG_PATH1_MAX:   r_bounds.max_hz[0] <= i_cfg_data;
                CFG_PATH2_MAX:   r_bounds.max_hz[1] <= i_cfg_data;
                CFG_PATH3_MAX:   r_bounds.max_hz[2] <= i_cfg_data;
                CFG_PATH4_MAX:   r_bounds.max_hz[3] <= i_cfg_data;
                CFG_PATH5_MAX:   r_bounds.max_hz[4] <= i_cfg_data;
                default:         r_synth_clock      <= r_synth_clock;
            endcase
        end
    end

    // Kept frequency; a request outside the overall limits leaves it as it was.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept <= '0;
        end else if (w_in_accept && w_req_ok) begin
            r_kept <= w_req;
        end
    end

    // Per-request payload held while the request is in progress.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_acc <= w_req_ok;
        end
        if (w_path_done) begin
            r_path <= w_path;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_PATH;
            ST_PATH: if (w_path_done)   n_state = ST_DIV;
            ST_DIV:  if (w_div_done)    n_state = ST_OUT;
            ST_OUT:  if (w_out_free)    n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Mid band halves the DDS frequency when a doubler path is in use.
    assign w_div_start = (r_state == ST_PATH) && w_path_done;
    assign w_dds = ((r_band == BAND_MID) && (w_path != '0)) ? (r_kept >> 1) : r_kept;

    dtbs_path_sel u_path_sel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_in_accept),
        .i_freq   (w_req_ok ? w_req : r_kept),
        .i_bounds (r_bounds),
        .o_done   (w_path_done),
        .o_path   (w_path)
    );

    dtbs_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dds),
        .i_divisor  (r_synth_clock),
        .o_done     (w_div_done),
        .o_result   (w_div_result)
    );

    // Output register parts the core from the result stream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_out_free) begin
            r_out_data <= {2'b00, w_div_result.ovf, w_div_result.word, r_path,
                           band_fits(r_kept, r_band), r_acc};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // An overflowed result always carries a zero word.
    a_ovf_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[37]) |-> (r_out_data[36:5] == '0))
        else $error("tuning word not zero on overflow");

    // The path code never goes above the last path.
    a_path_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[4:2] <= 3'd4))
        else $error("doubler path code out of range");

    // A new request is not taken in the cycle after one was accepted.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> !s_axis_tready)
        else $error("request taken while another is in progress");

    // Leaving the output state always leaves a valid result behind.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && w_out_free) |=> r_out_valid)
        else $error("result lost on the way to the output register");

endmodule

/* hdl/dtbs_path_sel.sv */
// Doubler path selector that tests one path edge per cycle with a shared comparator.
`timescale 1ns / 1ps

module dtbs_path_sel (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dtbs_pkg::HZ_W-1:0]      i_freq,
    input  dtbs_pkg::t_path_bounds         i_bounds,
    output logic                           o_done,
    output logic [dtbs_pkg::PATH_W-1:0]    o_path
);
    import dtbs_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [PATH_W-1:0]   r_step;
    logic [PATH_W-1:0]   r_path;
    logic [HZ_W-1:0]     r_freq;
    logic [HZ_W-1:0]     w_bound;
    logic                w_hit;
    logic                w_last;
    logic [PATH_W-1:0]   n_path;

    // Step zero tests the lower edge, steps one to five the upper edges in order.
    always_comb begin
        case (r_step)
            3'd0:    w_bound = i_bounds.min_hz;
            3'd1:    w_bound = i_bounds.max_hz[0];
            3'd2:    w_bound = i_bounds.max_hz[1];
            3'd3:    w_bound = i_bounds.max_hz[2];
            3'd4:    w_bound = i_bounds.max_hz[3];
            default: w_bound = i_bounds.max_hz[4];
        endcase
    end

    // Below the lower edge ends the search at once; otherwise the first upper edge
    // at or above the frequency gives the code, and no edge at all gives code zero.
    always_comb begin
        w_last = (r_step == PATH_W'(PATH_COUNT));
        if (r_step == '0) begin
            w_hit  = (r_freq < w_bound);
            n_path = '0;
        end else begin
            w_hit  = (r_freq <= w_bound) || w_last;
            n_path = (r_freq <= w_bound) ? (r_step - PATH_W'(1)) : '0;
        end
    end

    // Search control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (w_hit) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + PATH_W'(1);
                end
            end
        end
    end

    // Frequency under test and the chosen code.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_freq <= i_freq;
        end
        if (r_busy && w_hit) begin
            r_path <= n_path;
        end
    end

    assign o_done = r_done;
    assign o_path = r_path;

endmodule

/* hdl/dtbs_divider.sv */
// Radix-2 restoring divider that shifts one quotient bit in per cycle.
`timescale 1ns / 1ps

module dtbs_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dtbs_pkg::HZ_W-1:0]    i_dividend,
    input  logic [dtbs_pkg::HZ_W-1:0]    i_divisor,
    output logic                         o_done,
    output dtbs_pkg::t_div_result        o_result
);
    import dtbs_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [HZ_W-1:0]     r_rem;
    logic [HZ_W-1:0]     r_div;
    logic [WORD_W-1:0]   r_quot;
    logic                r_ovf;
    logic                w_start_ovf;
    logic [HZ_W:0]       w_shift;
    logic [HZ_W:0]       w_diff;
    logic                n_bit;
    logic [HZ_W-1:0]     n_rem;

    // A zero clock or a dividend not below the divisor gives a quotient of 2^32 or more.
    assign w_start_ovf = (i_divisor == '0) || (i_dividend >= i_divisor);

    // One restoring step: the remainder stays below the divisor, so 36 bits hold it.
    always_comb begin
        w_shift = {r_rem, 1'b0};
        w_diff  = w_shift - {1'b0, r_div};
        n_bit   = (w_shift >= {1'b0, r_div});
        n_rem   = n_bit ? w_diff[HZ_W-1:0] : w_shift[HZ_W-1:0];
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !w_start_ovf;
                r_done <= w_start_ovf;
                r_cnt  <= CNT_W'(WORD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_div  <= i_divisor;
            r_quot <= '0;
            r_ovf  <= w_start_ovf;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[WORD_W-2:0], n_bit};
        end
    end

    assign o_done          = r_done;
    assign o_result.ovf    = r_ovf;
    assign o_result.word   = r_quot;

endmodule
